@@ hdl/sps_pkg.sv @@
// Shared types and constants for the substring position search block.
// No dependencies; every other file in hdl/ imports this package.
package sps_pkg;

    // Default buffer length; the store keeps one entry less than this.
    localparam int BUF_LEN_DEF = 256;
    localparam int CH_W        = 8;
    localparam int POS_W       = 8;

    // Terminator byte for both the pattern and the text.
    localparam logic [CH_W-1:0] CH_NUL = 8'h00;

    // Item kinds.
    localparam logic KIND_PATTERN = 1'b0;
    localparam logic KIND_TEXT    = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] ch;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             status;
    } t_out_item;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic            shift;
        logic            step;
        logic            clear;
        logic [CH_W-1:0] ch;
    } t_cell_ctl;

    typedef enum logic {
        PH_PATTERN,
        PH_TEXT
    } t_phase;

endpackage

@@ hdl/sps_cell.sv @@
// One cell of the matching chain: a pattern byte and a partial-match bit.
// Depends on sps_pkg for the cell control struct.
module sps_cell
    import sps_pkg::*;
#(
    parameter int LEN_W = 8,
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [LEN_W-1:0] i_len,
    input  logic [CH_W-1:0]  i_pat_in,
    input  logic             i_match_in,
    output logic [CH_W-1:0]  o_pat,
    output logic             o_match,
    output logic             o_hit
);

    logic [CH_W-1:0] r_pat;
    logic            r_match;
    logic            n_match;
    logic            active;
    logic            first;

    // Pattern bytes shift in at cell 0, so the oldest byte sits in the highest
    // active cell. That cell starts a match; the others extend their neighbor's.
    always_comb begin
        active  = i_len > LEN_W'(INDEX);
        first   = i_len == LEN_W'(INDEX + 1);
        n_match = active && (first || i_match_in) && (i_ctl.ch == r_pat);
    end

    // The pattern byte moves one cell along on every stored pattern byte.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pat <= i_pat_in;
        end
    end

    // The partial-match bit advances on every counted text byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_match <= 1'b0;
        end else if (i_ctl.step) begin
            r_match <= n_match;
        end
    end

    assign o_pat   = r_pat;
    assign o_match = r_match;
    assign o_hit   = n_match;

endmodule

@@ hdl/sps_out_skid.sv @@
// Output register with a skid stage for the result channel.
// Depends on sps_pkg for the result struct.
module sps_out_skid
    import sps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_res_valid,
    input  t_out_item i_res,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      out_free;

    // The output register can take data when empty or when its transfer completes.
    assign out_free = !r_out_valid || !i_stall;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || i_res_valid;
            r_skid_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payloads: the skid stage drains first, a new result never meets a full skid.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_res_valid) begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

@@ hdl/substring_position_search.sv @@
// Top level of the substring position search: sequencer, cell chain, result buffer.
// Depends on sps_pkg, sps_cell and sps_out_skid.
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+-------------------------------
//  input    | i_valid | o_stall | i_item (kind, ch)
//  result   | o_valid | i_stall | o_item (found, position, status)
//
// One input item is taken every cycle while o_stall is low; every cell compares the
// text byte in the same cycle, and the partial-match bits move one cell per counted text byte.
// The text terminator's result is registered in the output register, or in the skid stage under i_stall.
// Reset is synchronous and active low; it needs no clearing pass.
// o_stall rises only while both result stages hold results that wait.
module substring_position_search
    import sps_pkg::*;
#(
    parameter int BUF_LEN = BUF_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int STORE_DEPTH = BUF_LEN - 1;
    localparam int LEN_W       = $clog2(BUF_LEN);

    t_phase           r_phase;
    t_phase           n_phase;
    logic [LEN_W-1:0] r_pat_len;
    logic [LEN_W-1:0] n_pat_len;
    logic             r_pat_bad;
    logic             n_pat_bad;
    logic [LEN_W-1:0] r_count;
    logic [LEN_W-1:0] n_count;
    logic             r_text_over;
    logic             n_text_over;
    logic             r_match_seen;
    logic             n_match_seen;
    logic [LEN_W-1:0] r_match_start;
    logic [LEN_W-1:0] n_match_start;

    t_cell_ctl        ctl;
    logic             accept;
    logic             res_valid;
    t_out_item        res;
    logic             bad;
    logic             found;
    logic             skid_full;

    logic [CH_W-1:0]  pat_in  [STORE_DEPTH];
    logic [CH_W-1:0]  pat_bus [STORE_DEPTH];
    logic             match_bus [STORE_DEPTH+1];
    logic             hit_bus [STORE_DEPTH];

    assign accept  = i_valid && !o_stall;
    assign o_stall = skid_full;

    // Phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PATTERN;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Sequencer: next phase, counters and the control broadcast to the cells.
    always_comb begin
        n_phase       = r_phase;
        n_pat_len     = r_pat_len;
        n_pat_bad     = r_pat_bad;
        n_count       = r_count;
        n_text_over   = r_text_over;
        n_match_seen  = r_match_seen;
        n_match_start = r_match_start;
        res_valid     = 1'b0;
        ctl           = '0;
        ctl.ch        = i_item.ch;
        case (r_phase)
            PH_PATTERN: begin
                if (accept && i_item.kind == KIND_PATTERN) begin
                    if (i_item.ch == CH_NUL) begin
                        n_phase = PH_TEXT;
                    end else if (r_pat_len != LEN_W'(STORE_DEPTH)) begin
                        ctl.shift = 1'b1;
                        n_pat_len = r_pat_len + LEN_W'(1);
                    end else begin
                        n_pat_bad = 1'b1;
                    end
                end
            end
            PH_TEXT: begin
                if (accept && i_item.kind == KIND_TEXT) begin
                    if (i_item.ch == CH_NUL) begin
                        res_valid     = 1'b1;
                        ctl.clear     = 1'b1;
                        n_phase       = PH_PATTERN;
                        n_pat_len     = '0;
                        n_pat_bad     = 1'b0;
                        n_count       = '0;
                        n_text_over   = 1'b0;
                        n_match_seen  = 1'b0;
                        n_match_start = '0;
                    end else if (r_count != LEN_W'(STORE_DEPTH)) begin
                        ctl.step = 1'b1;
                        n_count  = r_count + LEN_W'(1);
                        // Cell 0 holds the last pattern byte, so its hit is a full match.
                        if (!r_match_seen && !r_pat_bad && hit_bus[0]) begin
                            n_match_seen  = 1'b1;
                            n_match_start = r_count + LEN_W'(1) - r_pat_len;
                        end
                    end else begin
                        n_text_over = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_PATTERN;
            end
        endcase
    end

    // Search state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len    <= '0;
            r_pat_bad    <= 1'b0;
            r_count      <= '0;
            r_text_over  <= 1'b0;
            r_match_seen <= 1'b0;
        end else begin
            r_pat_len    <= n_pat_len;
            r_pat_bad    <= n_pat_bad;
            r_count      <= n_count;
            r_text_over  <= n_text_over;
            r_match_seen <= n_match_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match_start <= n_match_start;
    end

    // Result fields for the text terminator.
    always_comb begin
        bad          = r_pat_bad || r_text_over;
        found        = !bad && (r_pat_len == '0 || r_match_seen);
        res.found    = found;
        res.position = (found && r_pat_len != '0) ? POS_W'(r_match_start) : '0;
        res.status   = bad ? STATUS_BAD : STATUS_OK;
    end

    // The chain of cells; a match bit beyond the last cell always reads as set.
    assign match_bus[STORE_DEPTH] = 1'b1;

    for (genvar j = 0; j < STORE_DEPTH; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign pat_in[j] = i_item.ch;
        end else begin : g_body
            assign pat_in[j] = pat_bus[j-1];
        end

        sps_cell #(
            .LEN_W (LEN_W),
            .INDEX (j)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_len      (r_pat_len),
            .i_pat_in   (pat_in[j]),
            .i_match_in (match_bus[j+1]),
            .o_pat      (pat_bus[j]),
            .o_match    (match_bus[j]),
            .o_hit      (hit_bus[j])
        );
    end

    // Result register and skid stage.
    sps_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (skid_full),
        .o_valid     (o_valid),
        .o_item      (o_item),
        .i_stall     (i_stall)
    );

`ifndef SYNTH
    // A result comes only from the text phase.
    a_res_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> r_phase == PH_TEXT)
        else $error("result outside the text phase");

    // After a result the search state is back at an empty pattern.
    a_clear_after_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> (r_phase == PH_PATTERN && r_pat_len == '0 && !r_match_seen))
        else $error("search state not cleared after a result");

    // A recorded match lies wholly inside the counted text.
    a_match_in_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_match_seen |-> ((LEN_W+1)'(r_match_start) + (LEN_W+1)'(r_pat_len)
                          <= (LEN_W+1)'(r_count)))
        else $error("match start beyond counted text");

    // The skid stage only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        skid_full |-> o_valid)
        else $error("skid stage full with empty output register");

    // A text byte is counted only while the pattern length is settled.
    a_len_stable_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.step |=> $stable(r_pat_len))
        else $error("pattern length moved during text");
`endif

endmodule
